// ===== rtl/sst_pkg.sv =====
// Shared constants, types and helpers for the socket slot table.
`default_nettype none
package sst_pkg;

   localparam int SLOTS  = 8;
   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SLOT_W = 3;
   localparam int CMP_W  = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
   localparam int ADDR_W = 32;
   localparam int PORT_W = 16;
   localparam int KIND_W = 2;
   localparam int AP_W   = ADDR_W + PORT_W;
   localparam int PADDR_W = 2;

   localparam logic [PADDR_W-1:0] CSR_WILDCARD = 2'd0;

   typedef enum logic [1:0] {
      FUNC_OPEN   = 2'd0,
      FUNC_BIND   = 2'd1,
      FUNC_CLOSE  = 2'd2,
      FUNC_LOOKUP = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_WALK   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   // slot index as reported on the result port (low three bits)
   function automatic logic [SLOT_W-1:0] to_slot_out(input logic [IDX_W-1:0] idx);
      logic [CMP_W-1:0] ext;
      ext = CMP_W'(idx);
      return ext[SLOT_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/sst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ===== rtl/socket_slot_table.sv =====
// Socket slot table: open, bind, close and lookup over a fixed set of slots.
//
// Requests enter on req_* (valid/stall); one result per request leaves on
// rsp_* from an output register. One request is worked on at a time.
// Open, bind and close finish in the accept cycle; their result is
// registered, then moved from the finish state into the output register.
// Lookup walks the slots in order through the slot memories, one slot per
// cycle with registered read data, and stops at the first match or after
// the last slot. The walk sets the rate.
// The next request is taken once the result has moved into the output
// register; it may then wait there while the next request is worked on.
// A stalled result holds the block in its finish state, with req_stall high.
// Open slot flags reset to all closed; address, port and kind memories are
// not cleared, and their read data is used only for slots flagged open.
// The wildcard address (APB offset 0) resets to 0 and should only be
// written while no request is in flight.
`default_nettype none
module socket_slot_table (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [1:0]                   req_func,
   input  wire logic [2:0]                   req_slot,
   input  wire logic [1:0]                   req_sock_kind,
   input  wire logic [31:0]                  req_address,
   input  wire logic [15:0]                  req_port_number,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic                              rsp_found,
   output logic [2:0]                        rsp_slot_out,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [sst_pkg::PADDR_W-1:0]  paddr,
   input  wire logic [31:0]                  pwdata,
   output logic      [31:0]                  prdata,
   output logic                              pready
);

   localparam int IDX_W  = sst_pkg::IDX_W;
   localparam int CMP_W  = sst_pkg::CMP_W;
   localparam int SLOTS  = sst_pkg::SLOTS;

   sst_pkg::state_type state_ff, state_in;

   logic [SLOTS-1:0]               open_ff, open_in;
   logic [sst_pkg::ADDR_W-1:0]     wildcard_ff, wildcard_in;
   logic [IDX_W-1:0]               chk_ff, chk_in;
   logic [sst_pkg::KIND_W-1:0]     q_kind_ff, q_kind_in;
   logic [sst_pkg::ADDR_W-1:0]     q_addr_ff, q_addr_in;
   logic [sst_pkg::PORT_W-1:0]     q_port_ff, q_port_in;
   logic                           res_found_ff, res_found_in;
   logic [2:0]                     res_slot_ff, res_slot_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_found_ff, rsp_found_in;
   logic [2:0]                     rsp_slot_ff, rsp_slot_in;

   // memory ports
   logic                           ap_we, kind_we;
   logic [IDX_W-1:0]               wr_addr, rd_addr;
   logic [sst_pkg::AP_W-1:0]       ap_wdata, ap_rdata;
   logic [sst_pkg::KIND_W-1:0]     kind_wdata, kind_rdata;

   logic                           accept, out_free, free_hit, slot_ok, match;
   logic [IDX_W-1:0]               free_idx, slot_idx;
   logic [CMP_W-1:0]               slot_ext;
   logic [sst_pkg::ADDR_W-1:0]     rd_address;
   logic [sst_pkg::PORT_W-1:0]     rd_port;
   logic                           csr_wr;

   sst_ram #(.WIDTH(sst_pkg::AP_W), .DEPTH(SLOTS)) u_ap_ram (
      .clock   (clock),
      .wr_en   (ap_we),
      .wr_addr (wr_addr),
      .wr_data (ap_wdata),
      .rd_addr (rd_addr),
      .rd_data (ap_rdata)
   );

   sst_ram #(.WIDTH(sst_pkg::KIND_W), .DEPTH(SLOTS)) u_kind_ram (
      .clock   (clock),
      .wr_en   (kind_we),
      .wr_addr (wr_addr),
      .wr_data (kind_wdata),
      .rd_addr (rd_addr),
      .rd_data (kind_rdata)
   );

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr == sst_pkg::CSR_WILDCARD);
   assign prdata = (paddr == sst_pkg::CSR_WILDCARD) ? wildcard_ff : 32'd0;
   assign wildcard_in = csr_wr ? pwdata : wildcard_ff;

   assign req_stall    = (state_ff != sst_pkg::ST_IDLE);
   assign accept       = req_valid && !req_stall;
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_slot_out = rsp_slot_ff;

   assign slot_ext = CMP_W'(req_slot);
   assign slot_idx = slot_ext[IDX_W-1:0];
   assign slot_ok  = (int'(req_slot) < SLOTS);

   assign rd_address = ap_rdata[sst_pkg::AP_W-1:sst_pkg::PORT_W];
   assign rd_port    = ap_rdata[sst_pkg::PORT_W-1:0];
   assign match = open_ff[chk_ff] && (kind_rdata == q_kind_ff) && (rd_port == q_port_ff)
                  && ((rd_address == q_addr_ff) || (rd_address == wildcard_ff));

   // lowest closed slot
   always_comb begin
      free_hit = 1'b0;
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!open_ff[i]) begin
            free_hit = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      open_in      = open_ff;
      chk_in       = chk_ff;
      q_kind_in    = q_kind_ff;
      q_addr_in    = q_addr_ff;
      q_port_in    = q_port_ff;
      res_found_in = res_found_ff;
      res_slot_in  = res_slot_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_found_in = rsp_found_ff;
      rsp_slot_in  = rsp_slot_ff;
      ap_we        = 1'b0;
      kind_we      = 1'b0;
      wr_addr      = slot_idx;
      ap_wdata     = {req_address, req_port_number};
      kind_wdata   = req_sock_kind;
      rd_addr      = '0;

      case (state_ff)
         sst_pkg::ST_IDLE: begin
            if (accept) begin
               q_kind_in    = req_sock_kind;
               q_addr_in    = req_address;
               q_port_in    = req_port_number;
               res_found_in = 1'b1;
               res_slot_in  = req_slot;
               state_in     = sst_pkg::ST_FINISH;
               case (sst_pkg::func_type'(req_func))
                  sst_pkg::FUNC_OPEN: begin
                     wr_addr      = free_idx;
                     ap_wdata     = '0;
                     ap_we        = free_hit;
                     kind_we      = free_hit;
                     res_found_in = free_hit;
                     res_slot_in  = free_hit ? sst_pkg::to_slot_out(free_idx) : 3'd0;
                     if (free_hit) begin
                        open_in[free_idx] = 1'b1;
                     end
                  end
                  sst_pkg::FUNC_BIND: begin
                     ap_we = slot_ok;
                  end
                  sst_pkg::FUNC_CLOSE: begin
                     if (slot_ok) begin
                        open_in[slot_idx] = 1'b0;
                     end
                  end
                  sst_pkg::FUNC_LOOKUP: begin
                     chk_in   = '0;
                     state_in = sst_pkg::ST_WALK;
                  end
                  default: begin
                     state_in = sst_pkg::ST_FINISH;
                  end
               endcase
            end
         end
         sst_pkg::ST_WALK: begin
            // read data here belongs to slot chk_ff; next slot is read meanwhile
            rd_addr = IDX_W'({1'b0, chk_ff} + 1'b1);
            chk_in  = rd_addr;
            if (match) begin
               res_found_in = 1'b1;
               res_slot_in  = sst_pkg::to_slot_out(chk_ff);
               state_in     = sst_pkg::ST_FINISH;
            end else if (chk_ff == IDX_W'(SLOTS - 1)) begin
               res_found_in = 1'b0;
               res_slot_in  = 3'd0;
               state_in     = sst_pkg::ST_FINISH;
            end
         end
         sst_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_slot_in  = res_slot_ff;
               state_in     = sst_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sst_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sst_pkg::ST_IDLE;
         open_ff      <= '0;
         wildcard_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         open_ff      <= open_in;
         wildcard_ff  <= wildcard_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_ff       <= chk_in;
      q_kind_ff    <= q_kind_in;
      q_addr_ff    <= q_addr_in;
      q_port_ff    <= q_port_in;
      res_found_ff <= res_found_in;
      res_slot_ff  <= res_slot_in;
      rsp_found_ff <= rsp_found_in;
      rsp_slot_ff  <= rsp_slot_in;
   end

endmodule
`default_nettype wire
